>>> rtl/hase_pkg.sv
// Shared types, constants and register codes for the successor expand unit.
package hase_pkg;

    localparam int POS_WIDTH_DEF     = 32;
    localparam int HEADING_WIDTH_DEF = 16;

    // primitive rows per direction; index FWD_ROWS and above drive in reverse
    localparam int         FWD_ROWS  = 3;
    localparam logic [2:0] PRIM_LAST = 3'd5;

    localparam int TRIG_LAT    = 6;
    localparam int SQRT_LAT    = 32;
    localparam int QUEUE_DEPTH = 4;

    // configuration register indexes
    localparam logic [2:0] CFG_PRIM_STRAIGHT = 3'd0;
    localparam logic [2:0] CFG_PRIM_LEFT     = 3'd1;
    localparam logic [2:0] CFG_PRIM_RIGHT    = 3'd2;
    localparam logic [2:0] CFG_PENALTIES     = 3'd3;
    localparam logic [2:0] CFG_GOAL_X        = 3'd4;
    localparam logic [2:0] CFG_GOAL_Y        = 3'd5;

    localparam logic [47:0] PEN_RESET = 48'h0200_0200_010D;

    // odd quarter-wave sine polynomial, Q30, lowest order first
    localparam logic [30:0] POLY [5] = '{
        31'd1686629713, 31'd693598668, 31'd85569306, 31'd5026995, 31'd172272
    };

    // classified primitive, decided at the front
    typedef struct packed {
        logic               pen_t;
        logic               pen_r;
        logic               pen_c;
        logic               rev;
        logic [2:0]         idx;
        logic signed [16:0] u;
        logic signed [15:0] dy;
        logic [15:0]        dyaw;
    } t_cls;

    typedef struct packed {
        logic       rev;
        logic [2:0] idx;
    } t_tag;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic int entry_width(input int pw, input int hw);
        return 2 * pw + hw + 32 + $bits(t_cls);
    endfunction

endpackage

>>> rtl/hase_front.sv
// Front end: accepts node words and classifies the requested primitive.
module hase_front #(
    parameter int POS_WIDTH     = hase_pkg::POS_WIDTH_DEF,
    parameter int HEADING_WIDTH = hase_pkg::HEADING_WIDTH_DEF,
    parameter int QW            = hase_pkg::entry_width(POS_WIDTH, HEADING_WIDTH)
) (
    input  logic                            i_valid,
    input  hase_pkg::t_qstat                i_qstat,
    input  logic signed [POS_WIDTH-1:0]     i_cur_x,
    input  logic signed [POS_WIDTH-1:0]     i_cur_y,
    input  logic [HEADING_WIDTH-1:0]        i_cur_heading,
    input  logic [31:0]                     i_cur_cost,
    input  logic [2:0]                      i_parent_prim,
    input  logic [2:0]                      i_prim_index,
    input  logic [47:0]                     i_prim_straight,
    input  logic [47:0]                     i_prim_left,
    input  logic [47:0]                     i_prim_right,
    output logic                            o_push,
    output logic                            o_stall,
    output logic [QW-1:0]                   o_entry
);

    logic [2:0]         idx, par;
    logic               rev, par_rev, same;
    logic [2:0]         row;
    logic [47:0]        prim;
    logic signed [16:0] dx_ext;
    hase_pkg::t_cls     cls;

    always_comb begin
        // out-of-range codes act as the last reverse primitive
        idx     = (i_prim_index > hase_pkg::PRIM_LAST) ? hase_pkg::PRIM_LAST : i_prim_index;
        par     = (i_parent_prim > hase_pkg::PRIM_LAST) ? hase_pkg::PRIM_LAST : i_parent_prim;
        rev     = idx >= 3'(hase_pkg::FWD_ROWS);
        par_rev = par >= 3'(hase_pkg::FWD_ROWS);
        same    = par == idx;
        row     = rev ? idx - 3'(hase_pkg::FWD_ROWS) : idx;
        case (row)
            3'd0:    prim = i_prim_straight;
            3'd1:    prim = i_prim_left;
            default: prim = i_prim_right;
        endcase
        dx_ext    = 17'($signed(prim[15:0]));
        cls.pen_t = !same;
        cls.pen_r = rev;
        cls.pen_c = !same && (rev != par_rev);
        cls.rev   = rev;
        cls.idx   = idx;
        cls.u     = rev ? -dx_ext : dx_ext;
        cls.dy    = $signed(prim[31:16]);
        cls.dyaw  = prim[47:32];
    end

    assign o_stall = i_qstat.full;
    assign o_push  = i_valid && !i_qstat.full;
    assign o_entry = {i_cur_x, i_cur_y, i_cur_heading, i_cur_cost, cls};

endmodule

>>> rtl/hase_queue.sv
// Small word queue between front and back.
module hase_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = hase_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [WIDTH-1:0]  i_data,
    input  logic              i_pop,
    output logic [WIDTH-1:0]  o_data,
    output hase_pkg::t_qstat  o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CW'(i_push) - CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.full  = r_count == CW'(DEPTH);
    assign o_stat.empty = r_count == '0;

endmodule

>>> rtl/hase_qsine.sv
// Pipelined quarter-wave sine, Horner form, one multiply per stage.
module hase_qsine (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [30:0] i_x,
    output logic [30:0] o_y
);

    logic [30:0] r_x  [1:5];
    logic [30:0] r_x2 [1:4];
    logic [30:0] r_p  [2:5];
    logic [30:0] r_y;
    logic [61:0] sq, pm2, pm3, pm4, pm5, pmy;

    assign sq  = i_x * i_x;
    assign pm2 = r_x2[1] * hase_pkg::POLY[4];
    assign pm3 = r_x2[2] * r_p[2];
    assign pm4 = r_x2[3] * r_p[3];
    assign pm5 = r_x2[4] * r_p[4];
    assign pmy = r_x[5] * r_p[5];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[1]  <= i_x;
            r_x2[1] <= sq[60:30];
            for (int k = 2; k <= 5; k++) begin
                r_x[k] <= r_x[k-1];
            end
            for (int k = 2; k <= 4; k++) begin
                r_x2[k] <= r_x2[k-1];
            end
            r_p[2] <= 31'(33'(hase_pkg::POLY[3]) - 33'(pm2[61:30]));
            r_p[3] <= 31'(33'(hase_pkg::POLY[2]) - 33'(pm3[61:30]));
            r_p[4] <= 31'(33'(hase_pkg::POLY[1]) - 33'(pm4[61:30]));
            r_p[5] <= 31'(33'(hase_pkg::POLY[0]) - 33'(pm5[61:30]));
            // clamp to 1.0
            r_y <= (pmy[61:30] > 32'h4000_0000) ? 31'h4000_0000 : pmy[60:30];
        end
    end

    assign o_y = r_y;

endmodule

>>> rtl/hase_isqrt.sv
// Pipelined floor square root of a 64-bit word, one result bit per stage.
module hase_isqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_n,
    output logic [31:0] o_root
);

    localparam int N = hase_pkg::SQRT_LAT;

    logic [63:0] r_n   [1:N-1];
    logic [63:0] r_res [1:N];
    logic [63:0] w_n   [0:N-1];
    logic [63:0] w_res [0:N-1];

    always_comb begin
        w_n[0]   = i_n;
        w_res[0] = '0;
        for (int g = 1; g < N; g++) begin
            w_n[g]   = r_n[g];
            w_res[g] = r_res[g];
        end
    end

    always_ff @(posedge i_clk) begin
        logic [63:0] bitv;
        logic [63:0] trial;
        if (i_en) begin
            for (int g = 0; g < N; g++) begin
                bitv  = 64'd1 << (62 - 2 * g);
                trial = w_res[g] + bitv;
                r_res[g+1] <= (w_n[g] >= trial) ? (w_res[g] >> 1) + bitv : w_res[g] >> 1;
            end
            for (int g = 0; g < N - 1; g++) begin
                bitv  = 64'd1 << (62 - 2 * g);
                trial = w_res[g] + bitv;
                r_n[g+1] <= (w_n[g] >= trial) ? w_n[g] - trial : w_n[g];
            end
        end
    end

    assign o_root = r_res[N][31:0];

endmodule

>>> rtl/hase_back.sv
// Back end: rotation, heading, step cost and goal distance pipeline.
module hase_back #(
    parameter int POS_WIDTH     = hase_pkg::POS_WIDTH_DEF,
    parameter int HEADING_WIDTH = hase_pkg::HEADING_WIDTH_DEF,
    parameter int QW            = hase_pkg::entry_width(POS_WIDTH, HEADING_WIDTH)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic [QW-1:0]                    i_entry,
    output logic                             o_ready,
    input  logic                             i_stall,
    input  logic [15:0]                      i_straight_dx,
    input  logic [47:0]                      i_pen,
    input  logic [31:0]                      i_goal_x,
    input  logic [31:0]                      i_goal_y,
    output logic                             o_valid,
    output logic signed [POS_WIDTH-1:0]      o_succ_x,
    output logic signed [POS_WIDTH-1:0]      o_succ_y,
    output logic [HEADING_WIDTH-1:0]         o_succ_heading,
    output logic [31:0]                      o_succ_cost,
    output logic [31:0]                      o_goal_dist,
    output logic                             o_succ_reverse,
    output logic [2:0]                       o_succ_prim
);

    localparam int PW      = POS_WIDTH;
    localparam int HW      = HEADING_WIDTH;
    localparam int ST_COST = 5;
    localparam int ST_TRIG = 1 + hase_pkg::TRIG_LAT;
    localparam int ST_PROD = ST_TRIG + 1;
    localparam int ST_POS  = ST_PROD + 1;
    localparam int ST_DIFF = ST_POS + 1;
    localparam int ST_SQ   = ST_DIFF + 1;
    localparam int ST_SUM  = ST_SQ + 1;
    localparam int LAT     = ST_SUM + hase_pkg::SQRT_LAT;

    logic signed [PW-1:0] e_x, e_y;
    logic [HW-1:0]        e_head;
    logic [31:0]          e_cost;
    hase_pkg::t_cls       e_cls;

    assign {e_x, e_y, e_head, e_cost, e_cls} = i_entry;

    logic                 r_vld   [1:LAT];
    hase_pkg::t_tag       r_tag   [1:LAT];
    logic [HW-1:0]        r_head  [1:LAT];
    logic [31:0]          r_cost  [1:LAT];
    logic signed [PW-1:0] r_x     [1:ST_PROD];
    logic signed [PW-1:0] r_y     [1:ST_PROD];
    logic signed [16:0]   r_u     [1:ST_TRIG];
    logic signed [15:0]   r_dy    [1:ST_TRIG];
    logic [1:0]           r_q     [1:ST_TRIG];
    hase_pkg::t_cls       r_cls   [1:3];
    logic [30:0]          r_fs, r_fc;
    logic signed [32:0]   r_step1;
    logic signed [40:0]   r_step2;
    logic signed [41:0]   r_step3;
    logic signed [48:0]   r_uc, r_dys, r_us, r_dyc;
    logic signed [PW-1:0] r_xn    [ST_POS:LAT];
    logic signed [PW-1:0] r_yn    [ST_POS:LAT];
    logic [31:0]          r_ax, r_ay;
    logic                 r_big10, r_big11;
    logic [63:0]          r_a2, r_b2, r_sum;
    logic                 r_ovf   [ST_SUM:LAT];

    logic adv;
    assign adv     = !(r_vld[LAT] && i_stall);
    assign o_ready = adv;

    // stage 1 inputs
    logic [31:0]      ang;
    logic [HW+15:0]   delta_full;
    logic [HW-1:0]    delta, n_head;
    hase_pkg::t_tag   n_tag;

    always_comb begin
        ang        = 32'(e_head) << (32 - HW);
        delta_full = {e_cls.dyaw, HW'(0)};
        delta      = delta_full[HW+15:16];
        n_head     = e_cls.rev ? e_head - delta : e_head + delta;
        n_tag.rev  = e_cls.rev;
        n_tag.idx  = e_cls.idx;
    end

    // step cost chain: turning, reversing, direction change
    logic signed [23:0] step0;
    logic signed [16:0] pt, pr, pc;
    logic signed [40:0] m1, rn1;
    logic signed [49:0] m2, rn2;
    logic signed [57:0] m3, rn3;
    logic signed [41:0] cl3;
    logic signed [42:0] csum;
    logic [31:0]        n_cost;

    localparam logic signed [57:0] PEN_MAX = 58'sd1 <<< 40;

    always_comb begin
        step0 = {i_straight_dx, 8'h00};
        pt    = $signed({1'b0, i_pen[15:0]});
        pr    = $signed({1'b0, i_pen[31:16]});
        pc    = $signed({1'b0, i_pen[47:32]});
        m1    = step0 * pt;
        rn1   = (m1 + 41'sd128) >>> 8;
        m2    = r_step1 * pr;
        rn2   = (m2 + 50'sd128) >>> 8;
        m3    = r_step2 * pc;
        rn3   = (m3 + 58'sd128) >>> 8;
        // only the last factor can reach the clamp
        if (rn3 > PEN_MAX) begin
            cl3 = 42'(PEN_MAX);
        end else if (rn3 < -PEN_MAX) begin
            cl3 = 42'(-PEN_MAX);
        end else begin
            cl3 = rn3[41:0];
        end
        csum = $signed({11'b0, r_cost[ST_COST-1]}) + 43'(r_step3);
        if (csum < 0) begin
            n_cost = '0;
        end else if (csum > 43'sd4294967295) begin
            n_cost = '1;
        end else begin
            n_cost = csum[31:0];
        end
    end

    // sine / cosine lanes
    logic [30:0] sp, cp;

    hase_qsine u_sin (.i_clk(i_clk), .i_en(adv), .i_x(r_fs), .o_y(sp));
    hase_qsine u_cos (.i_clk(i_clk), .i_en(adv), .i_x(r_fc), .o_y(cp));

    logic signed [31:0] ss, sc, s, c;
    logic signed [49:0] sx, sy, ox, oy, xs, ys;

    always_comb begin
        ss = $signed({1'b0, sp});
        sc = $signed({1'b0, cp});
        case (r_q[ST_TRIG])
            2'd0: begin s = ss;  c = sc;  end
            2'd1: begin s = sc;  c = -ss; end
            2'd2: begin s = -ss; c = -sc; end
            default: begin s = -sc; c = ss; end
        endcase
        // products are Q.38, round half up to Q16.16
        sx = 50'(r_uc) - 50'(r_dys) + 50'sd2097152;
        sy = 50'(r_us) + 50'(r_dyc) + 50'sd2097152;
        ox = sx >>> 22;
        oy = sy >>> 22;
        xs = 50'(r_x[ST_PROD]) + ox;
        ys = 50'(r_y[ST_PROD]) + oy;
    end

    // goal difference
    logic signed [PW-1:0] gx, gy;
    logic signed [PW:0]   dgx, dgy;
    logic [PW:0]          agx, agy;
    logic [63:0]          ax64, ay64;
    logic [64:0]          sum65;

    always_comb begin
        gx    = PW'(i_goal_x);
        gy    = PW'(i_goal_y);
        dgx   = (PW+1)'(gx) - (PW+1)'(r_xn[ST_POS]);
        dgy   = (PW+1)'(gy) - (PW+1)'(r_yn[ST_POS]);
        agx   = dgx[PW] ? -dgx : dgx;
        agy   = dgy[PW] ? -dgy : dgy;
        ax64  = 64'(agx);
        ay64  = 64'(agy);
        sum65 = {1'b0, r_a2} + {1'b0, r_b2};
    end

    logic [31:0] root;

    hase_isqrt u_isqrt (.i_clk(i_clk), .i_en(adv), .i_n(r_sum), .o_root(root));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (adv) begin
            r_vld[1] <= i_valid;
            for (int k = 2; k <= LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_tag[1]  <= n_tag;
            r_head[1] <= n_head;
            r_cost[1] <= e_cost;
            r_x[1]    <= e_x;
            r_y[1]    <= e_y;
            r_u[1]    <= e_cls.u;
            r_dy[1]   <= e_cls.dy;
            r_q[1]    <= ang[31:30];
            r_cls[1]  <= e_cls;
            r_fs      <= {1'b0, ang[29:0]};
            r_fc      <= 31'h4000_0000 - {1'b0, ang[29:0]};
            for (int k = 2; k <= LAT; k++) begin
                r_tag[k]  <= r_tag[k-1];
                r_head[k] <= r_head[k-1];
                if (k != ST_COST) begin
                    r_cost[k] <= r_cost[k-1];
                end
            end
            r_cost[ST_COST] <= n_cost;
            for (int k = 2; k <= ST_PROD; k++) begin
                r_x[k] <= r_x[k-1];
                r_y[k] <= r_y[k-1];
            end
            for (int k = 2; k <= ST_TRIG; k++) begin
                r_u[k]  <= r_u[k-1];
                r_dy[k] <= r_dy[k-1];
                r_q[k]  <= r_q[k-1];
            end
            for (int k = 2; k <= 3; k++) begin
                r_cls[k] <= r_cls[k-1];
            end
            r_step1 <= r_cls[1].pen_t ? rn1[32:0] : 33'(step0);
            r_step2 <= r_cls[2].pen_r ? rn2[40:0] : 41'(r_step1);
            r_step3 <= r_cls[3].pen_c ? cl3 : 42'(r_step2);
            r_uc  <= r_u[ST_TRIG] * c;
            r_dys <= r_dy[ST_TRIG] * s;
            r_us  <= r_u[ST_TRIG] * s;
            r_dyc <= r_dy[ST_TRIG] * c;
            r_xn[ST_POS] <= xs[PW-1:0];
            r_yn[ST_POS] <= ys[PW-1:0];
            for (int k = ST_POS + 1; k <= LAT; k++) begin
                r_xn[k] <= r_xn[k-1];
                r_yn[k] <= r_yn[k-1];
            end
            r_ax    <= ax64[31:0];
            r_ay    <= ay64[31:0];
            r_big10 <= (|ax64[63:32]) || (|ay64[63:32]);
            r_a2    <= r_ax * r_ax;
            r_b2    <= r_ay * r_ay;
            r_big11 <= r_big10;
            r_sum   <= sum65[63:0];
            r_ovf[ST_SUM] <= r_big11 || sum65[64];
            for (int k = ST_SUM + 1; k <= LAT; k++) begin
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_valid        = r_vld[LAT];
    assign o_succ_x       = r_xn[LAT];
    assign o_succ_y       = r_yn[LAT];
    assign o_succ_heading = r_head[LAT];
    assign o_succ_cost    = r_cost[LAT];
    assign o_goal_dist    = r_ovf[LAT] ? '1 : root;
    assign o_succ_reverse = r_tag[LAT].rev;
    assign o_succ_prim    = r_tag[LAT].idx;

endmodule

>>> rtl/hybrid_astar_successor_expand_unit.sv
// Top level of the successor expand unit: config registers, front, queue, back.
//
//  channel   direction  handshake                 word
//  -------   ---------  ------------------------  --------------------------------
//  node in   in         i_valid / o_stall         node, parent and primitive index
//  succ out  out        o_valid / i_stall         successor, cost, goal distance
//  cfg       in         i_cfg_valid / o_cfg_ready register index and data
//
// One word per cycle sustained unless the output stalls. After the 4-word queue,
// words run from queue head to output register through 1 capture, 6 sine/cosine
// Horner stages, rotate, add, goal diff, square, sum and 32 square-root stages.
// Reset is synchronous active low; it clears valid bits, queue pointers and
// sets the config registers to their defaults. An output stall freezes the
// whole back pipeline; the queue keeps taking words until it fills.
module hybrid_astar_successor_expand_unit #(
    parameter int POS_WIDTH     = hase_pkg::POS_WIDTH_DEF,
    parameter int HEADING_WIDTH = hase_pkg::HEADING_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [POS_WIDTH-1:0]   i_cur_x,
    input  logic signed [POS_WIDTH-1:0]   i_cur_y,
    input  logic [HEADING_WIDTH-1:0]      i_cur_heading,
    input  logic [31:0]                   i_cur_cost,
    input  logic [2:0]                    i_parent_prim,
    input  logic [2:0]                    i_prim_index,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [POS_WIDTH-1:0]   o_succ_x,
    output logic signed [POS_WIDTH-1:0]   o_succ_y,
    output logic [HEADING_WIDTH-1:0]      o_succ_heading,
    output logic [31:0]                   o_succ_cost,
    output logic [31:0]                   o_goal_dist,
    output logic                          o_succ_reverse,
    output logic [2:0]                    o_succ_prim,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [2:0]                    i_cfg_index,
    input  logic [47:0]                   i_cfg_data
);

    localparam int QW = hase_pkg::entry_width(POS_WIDTH, HEADING_WIDTH);

    // config registers; the user must write them only while idle, the block does not enforce it
    logic [47:0] r_prim_straight, r_prim_left, r_prim_right, r_penalties;
    logic [31:0] r_goal_x, r_goal_y;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prim_straight <= '0;
            r_prim_left     <= '0;
            r_prim_right    <= '0;
            r_penalties     <= hase_pkg::PEN_RESET;
            r_goal_x        <= '0;
            r_goal_y        <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                hase_pkg::CFG_PRIM_STRAIGHT: r_prim_straight <= i_cfg_data;
                hase_pkg::CFG_PRIM_LEFT:     r_prim_left     <= i_cfg_data;
                hase_pkg::CFG_PRIM_RIGHT:    r_prim_right    <= i_cfg_data;
                hase_pkg::CFG_PENALTIES:     r_penalties     <= i_cfg_data;
                hase_pkg::CFG_GOAL_X:        r_goal_x        <= i_cfg_data[31:0];
                hase_pkg::CFG_GOAL_Y:        r_goal_y        <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    hase_pkg::t_qstat w_qstat;
    logic             w_push, w_pop, w_back_ready;
    logic [QW-1:0]    w_entry, w_head;

    hase_front #(
        .POS_WIDTH(POS_WIDTH), .HEADING_WIDTH(HEADING_WIDTH), .QW(QW)
    ) u_front (
        .i_valid(i_valid), .i_qstat(w_qstat),
        .i_cur_x(i_cur_x), .i_cur_y(i_cur_y), .i_cur_heading(i_cur_heading),
        .i_cur_cost(i_cur_cost), .i_parent_prim(i_parent_prim),
        .i_prim_index(i_prim_index),
        .i_prim_straight(r_prim_straight), .i_prim_left(r_prim_left),
        .i_prim_right(r_prim_right),
        .o_push(w_push), .o_stall(o_stall), .o_entry(w_entry)
    );

    // pop whenever the back pipeline moves and a word is waiting
    assign w_pop = w_back_ready && !w_qstat.empty;

    hase_queue #(.WIDTH(QW), .DEPTH(hase_pkg::QUEUE_DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(w_push), .i_data(w_entry),
        .i_pop(w_pop), .o_data(w_head), .o_stat(w_qstat)
    );

    hase_back #(
        .POS_WIDTH(POS_WIDTH), .HEADING_WIDTH(HEADING_WIDTH), .QW(QW)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(!w_qstat.empty), .i_entry(w_head), .o_ready(w_back_ready),
        .i_stall(i_stall),
        .i_straight_dx(r_prim_straight[15:0]), .i_pen(r_penalties),
        .i_goal_x(r_goal_x), .i_goal_y(r_goal_y),
        .o_valid(o_valid), .o_succ_x(o_succ_x), .o_succ_y(o_succ_y),
        .o_succ_heading(o_succ_heading), .o_succ_cost(o_succ_cost),
        .o_goal_dist(o_goal_dist), .o_succ_reverse(o_succ_reverse),
        .o_succ_prim(o_succ_prim)
    );

`ifndef NO_ASSERTIONS
    a_rev_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_succ_reverse == (o_succ_prim >= 3'(hase_pkg::FWD_ROWS))))
        else $error("reverse flag disagrees with primitive index");

    a_prim_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_succ_prim <= hase_pkg::PRIM_LAST))
        else $error("primitive index out of range at output");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("output valid or stall set after reset");
`endif

endmodule
